>>> design/min_max_height_normalizer_defines.svh
// assertion macros for the min/max height normalizer
// no dependencies; included by files that carry concurrent assertions
`ifndef MIN_MAX_HEIGHT_NORMALIZER_DEFINES_SVH
`define MIN_MAX_HEIGHT_NORMALIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MMHN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMHN_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMHN_ASSERT(label, prop, msg)
`define MMHN_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> design/mmhn_pkg.sv
// shared constants, types and command structs of the min/max height normalizer
// no dependencies
package mmhn_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int FACTOR_FRAC_BITS = 16;
  localparam int LEVEL_BITS       = 8;
  localparam int FACTOR_BITS      = LEVEL_BITS + FACTOR_FRAC_BITS;
  localparam int RANGE_BITS       = SAMPLE_BITS + 1;
  localparam int VAL_BITS         = SAMPLE_BITS + 2;
  localparam int MAG_BITS         = SAMPLE_BITS + 1;
  localparam int PROD_BITS        = MAG_BITS + FACTOR_BITS;
  localparam int QUO_BITS         = PROD_BITS - FACTOR_FRAC_BITS;
  localparam int Q_LIMIT          = 1024;
  localparam int QC_BITS          = $clog2(Q_LIMIT) + 1;
  localparam int SUM_BITS         = QC_BITS + 2;
  localparam int CNT_BITS         = $clog2(FACTOR_BITS);
  localparam int CFG_IDX_BITS     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE = CFG_IDX_BITS'(1);

  localparam logic [LEVEL_BITS-1:0] PEAK_RESET = {LEVEL_BITS{1'b1}};
  localparam logic [LEVEL_BITS-1:0] BASE_RESET = '0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = {LEVEL_BITS{1'b1}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEVEL_BITS-1:0]         level_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic div_last;
    logic mul;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic flat_now;
  } dp_stat_t;

endpackage

>>> design/mmhn_in_if.sv
// sample request channel of the min/max height normalizer
// depends on mmhn_pkg
interface mmhn_in_if;
  import mmhn_pkg::*;

  logic    valid;
  logic    ready;
  logic    action;
  sample_t sample;
  logic    first_of_pass;

  modport source (output valid, action, sample, first_of_pass, input ready);
  modport sink (input valid, action, sample, first_of_pass, output ready);
endinterface

>>> design/mmhn_out_if.sv
// height result channel of the min/max height normalizer
// depends on mmhn_pkg
interface mmhn_out_if;
  import mmhn_pkg::*;

  logic   valid;
  logic   ready;
  level_t height;
  logic   flat_range;

  modport source (output valid, height, flat_range, input ready);
  modport sink (input valid, height, flat_range, output ready);
endinterface

>>> design/mmhn_cfg_if.sv
// register write channel of the min/max height normalizer
// depends on mmhn_pkg
interface mmhn_cfg_if;
  import mmhn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  level_t                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/min_max_height_normalizer.sv
// Min/max height normalizer, top level.
// Channels: in_chan takes requests {action, sample, first_of_pass}; out_chan
// returns {height, flat_range}; cfg_chan writes peak_level (index 0) and
// base_level (index 1). All use valid/ready, accepted when both are high.
// A gather request (action 0) updates the running min/max in its accept cycle
// and gives no result; gather requests are taken one per cycle when idle.
// A scale request (action 1) gives one result. After accept the controller
// passes through ST_MUL (product register) and ST_FIN (result register),
// then returns to ST_IDLE and takes the next request. The first scale request
// of a pass first runs the 24-step bit-serial divider (ST_DIV) for the factor;
// a flat range skips the divider.
// cfg_chan is always ready; write only while no scale request is in flight.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// statistics, zeroes factor and shift and drops out_chan.valid.
// A stalled receiver holds the result in the output register; one more scale
// request can be worked up to its result, then in_chan.ready stays low.
// Depends on mmhn_pkg, the mmhn interfaces, mmhn_ctrl and mmhn_datapath.
module min_max_height_normalizer (
  input  logic          clk,
  input  logic          rst_n,
  mmhn_in_if.sink       in_chan,
  mmhn_out_if.source    out_chan,
  mmhn_cfg_if.sink      cfg_chan
);
  import mmhn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;
  level_t   height;
  logic     flat_range;

  assign cfg_chan.ready = 1'b1;

  mmhn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_first  (in_chan.first_of_pass),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmhn_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (in_chan.action),
    .in_sample  (in_chan.sample),
    .in_first   (in_chan.first_of_pass),
    .cfg_we     (cfg_chan.valid),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .height     (height),
    .flat_range (flat_range)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.height     = height;
  assign out_chan.flat_range = flat_range;

endmodule

>>> design/mmhn_datapath.sv
// datapath: level registers, running min/max, bit-serial factor divider,
// scaling multiplier and output clamp; depends on mmhn_pkg
module mmhn_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mmhn_pkg::dp_cmd_t                   cmd,
  output mmhn_pkg::dp_stat_t                  stat,
  input  logic                                in_action,
  input  mmhn_pkg::sample_t                   in_sample,
  input  logic                                in_first,
  input  logic                                cfg_we,
  input  logic [mmhn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  mmhn_pkg::level_t                    cfg_data,
  output mmhn_pkg::level_t                    height,
  output logic                                flat_range
);
  import mmhn_pkg::*;

  level_t                        peak_r;
  level_t                        base_r;
  sample_t                       min_r;
  sample_t                       max_r;
  logic [FACTOR_BITS-1:0]        factor_r;
  logic [SAMPLE_BITS-1:0]        shift_r;
  logic                          flat_r;
  sample_t                       samp_r;
  logic [FACTOR_BITS-1:0]        num_r;
  logic [SAMPLE_BITS-1:0]        rem_r;
  logic [SAMPLE_BITS-1:0]        den_r;
  logic [PROD_BITS-1:0]          prod_r;
  logic                          neg_r;
  level_t                        height_r;
  logic                          flat_out_r;

  logic signed [RANGE_BITS-1:0]  range;
  logic [SAMPLE_BITS:0]          partial;
  logic [SAMPLE_BITS:0]          trial;
  logic                          ge;
  logic [SAMPLE_BITS-1:0]        rem_nxt;
  logic [FACTOR_BITS-1:0]        quo_nxt;
  logic signed [VAL_BITS-1:0]    val;
  logic [VAL_BITS-1:0]           mag_full;
  logic [MAG_BITS-1:0]           mag;
  logic [PROD_BITS-1:0]          prod;
  logic [QUO_BITS-1:0]           quo;
  logic [QC_BITS-1:0]            qc;
  logic signed [SUM_BITS-1:0]    sum;
  level_t                        height_nxt;

  // range and flat detection
  assign range         = RANGE_BITS'(max_r) - RANGE_BITS'(min_r);
  assign stat.flat_now = range[RANGE_BITS-1] || (range == '0);

  // restoring divider step
  assign partial = {rem_r, num_r[FACTOR_BITS-1]};
  assign trial   = partial - {1'b0, den_r};
  assign ge      = (partial >= {1'b0, den_r});
  assign rem_nxt = ge ? trial[SAMPLE_BITS-1:0] : partial[SAMPLE_BITS-1:0];
  assign quo_nxt = {num_r[FACTOR_BITS-2:0], ge};

  // offset, magnitude and product
  assign val      = VAL_BITS'(samp_r) + $signed({2'b00, shift_r});
  assign mag_full = val[VAL_BITS-1] ? VAL_BITS'(-val) : VAL_BITS'(val);
  assign mag      = mag_full[MAG_BITS-1:0];
  assign prod     = mag * factor_r;

  // truncate, limit, add to or subtract from base and clamp to a byte
  assign quo = prod_r[PROD_BITS-1:FACTOR_FRAC_BITS];
  assign qc  = (quo > QUO_BITS'(Q_LIMIT)) ? QC_BITS'(Q_LIMIT) : quo[QC_BITS-1:0];
  assign sum = neg_r ? ($signed(SUM_BITS'(base_r)) - $signed(SUM_BITS'(qc)))
                     : ($signed(SUM_BITS'(base_r)) + $signed(SUM_BITS'(qc)));

  always_comb begin
    if (sum[SUM_BITS-1]) begin
      height_nxt = '0;
    end else if (sum > $signed(SUM_BITS'(LEVEL_MAX))) begin
      height_nxt = LEVEL_MAX;
    end else begin
      height_nxt = sum[LEVEL_BITS-1:0];
    end
  end

  // level registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= PEAK_RESET;
      base_r <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PEAK: peak_r <= cfg_data;
        REG_BASE: base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // running statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else if (cmd.take && !in_action) begin
      if (in_first) begin
        min_r <= in_sample;
        max_r <= in_sample;
      end else begin
        if (in_sample < min_r) begin
          min_r <= in_sample;
        end
        if (in_sample > max_r) begin
          max_r <= in_sample;
        end
      end
    end
  end

  // per-pass scale state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= '0;
      shift_r  <= '0;
      flat_r   <= 1'b0;
    end else if (cmd.take && in_action && in_first) begin
      shift_r <= min_r[SAMPLE_BITS-1] ? (~min_r + 1'b1) : '0;
      flat_r  <= stat.flat_now;
      if (stat.flat_now) begin
        factor_r <= '0;
      end
    end else if (cmd.div_last) begin
      factor_r <= quo_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take && in_action) begin
      samp_r <= in_sample;
      if (in_first) begin
        num_r <= {peak_r, FACTOR_FRAC_BITS'(0)};
        rem_r <= '0;
        den_r <= range[SAMPLE_BITS-1:0];
      end
    end else if (cmd.div_step) begin
      num_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.mul) begin
      prod_r <= prod;
      neg_r  <= val[VAL_BITS-1];
    end
    if (cmd.load_out) begin
      height_r   <= height_nxt;
      flat_out_r <= flat_r;
    end
  end

  assign height     = height_r;
  assign flat_range = flat_out_r;

endmodule

>>> design/mmhn_ctrl.sv
// controller: request acceptance, divider sequencing and result handoff
// depends on mmhn_pkg and min_max_height_normalizer_defines.svh
`include "min_max_height_normalizer_defines.svh"
module mmhn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  input  logic               in_first,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mmhn_pkg::dp_stat_t stat,
  output mmhn_pkg::dp_cmd_t  cmd
);
  import mmhn_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] cnt_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.take  = in_fire;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_action) begin
          if (in_first && !stat.flat_now) begin
            state_nxt = ST_DIV;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(FACTOR_BITS - 1)) begin
          cmd.div_last = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `MMHN_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset not idle")
  `MMHN_ASSERT(a_gather_stays, (in_fire && !in_action) |=> (state_r == ST_IDLE), "gather left idle")
  `MMHN_ASSERT(a_scale_starts, (in_fire && in_action) |=> (state_r == ST_DIV || state_r == ST_MUL), "scale not started")
  `MMHN_ASSERT(a_div_bound, (state_r == ST_DIV) |-> (cnt_r <= CNT_BITS'(FACTOR_BITS - 1)), "divider overrun")
  `MMHN_ASSERT(a_mul_to_fin, (state_r == ST_MUL) |=> (state_r == ST_FIN), "product not finished")

endmodule
